// ===== rtl/core/xrng_pkg.sv =====
// xrng_pkg: shared widths and constants for the xorshift128+ ranged generator.
// No dependencies; imported by every module under rtl/core.
`timescale 1ns / 1ps

package xrng_pkg;

  localparam int WordW  = 64;
  localparam int RangeW = 32;

  // splitmix64 constants
  localparam logic [WordW-1:0] GoldenStep = 64'h9E3779B97F4A7C15;
  localparam logic [WordW-1:0] MixMulA    = 64'hBF58476D1CE4E5B9;
  localparam logic [WordW-1:0] MixMulB    = 64'h94D049BB133111EB;

  localparam int MixShift0 = 30;
  localparam int MixShift1 = 27;
  localparam int MixShift2 = 31;

  // xorshift128+ shift amounts
  localparam int XsShiftA = 23;
  localparam int XsShiftB = 17;
  localparam int XsShiftC = 26;

  typedef logic [WordW-1:0]  word_t;
  typedef logic [RangeW-1:0] range_t;

  // Handshake between the sequencer and a bit-serial unit
  typedef struct packed {
    logic start;
  } unit_ctl_t;

  typedef struct packed {
    logic done;
  } unit_sts_t;

endpackage

// ===== rtl/core/xrng_mul.sv =====
// xrng_mul: bit-serial shift-and-add multiplier, low 64 bits of the product.
// Depends on xrng_pkg. One multiplier bit per cycle.
`timescale 1ns / 1ps

module xrng_mul (
  input  logic              clk,
  input  logic              rst,
  input  xrng_pkg::unit_ctl_t ctl,
  input  xrng_pkg::word_t   multiplicand,
  input  xrng_pkg::word_t   multiplier,
  output xrng_pkg::unit_sts_t sts,
  output xrng_pkg::word_t   product
);
  import xrng_pkg::*;

  localparam int CntW = $clog2(WordW);

  logic            busy;
  logic [CntW-1:0] count;
  word_t           mcand;
  word_t           mplier;
  word_t           acc;
  logic            done;

  // Control: step through every multiplier bit after start, pulse done at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CntW'(WordW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: add the shifted multiplicand for each set multiplier bit
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mcand  <= multiplicand;
      mplier <= multiplier;
      acc    <= '0;
    end else if (busy) begin
      acc    <= acc + (mplier[0] ? mcand : '0);
      mcand  <= {mcand[WordW-2:0], 1'b0};
      mplier <= {1'b0, mplier[WordW-1:1]};
    end
  end

  assign sts.done = done;
  assign product  = acc;

endmodule

// ===== rtl/core/xrng_mod.sv =====
// xrng_mod: bit-serial restoring divider giving a 64-by-32-bit remainder.
// Depends on xrng_pkg. One quotient bit per cycle; divisor must be nonzero.
`timescale 1ns / 1ps

module xrng_mod (
  input  logic                clk,
  input  logic                rst,
  input  xrng_pkg::unit_ctl_t ctl,
  input  xrng_pkg::word_t     dividend,
  input  xrng_pkg::range_t    divisor,
  output xrng_pkg::unit_sts_t sts,
  output xrng_pkg::range_t    remainder
);
  import xrng_pkg::*;

  localparam int CntW = $clog2(WordW);

  logic            busy;
  logic [CntW-1:0] count;
  logic            done;
  word_t           dvd;
  range_t          dvs;
  range_t          rem;
  logic [RangeW:0] rem_sh;
  logic [RangeW:0] diff;

  // Shift in the next dividend bit and try the subtract
  assign rem_sh = {rem, dvd[WordW-1]};
  assign diff   = rem_sh - {1'b0, dvs};

  // Control: WordW steps after start, pulse done at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CntW'(WordW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: keep the difference when no borrow, else the shifted value
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[WordW-2:0], 1'b0};
      rem <= diff[RangeW] ? rem_sh[RangeW-1:0] : diff[RangeW-1:0];
    end
  end

  assign sts.done  = done;
  assign remainder = rem;

endmodule

// ===== rtl/core/xorshift128plus_ranged_rng_unit.sv =====
// Top level of the xorshift128+ ranged generator: sequencer, state words, output register.
// Depends on xrng_pkg, xrng_mul and xrng_mod.
`timescale 1ns / 1ps

// Random number generator with two 64-bit state words. A draw word (kind 0)
// advances xorshift128+ and returns the 64-bit sum plus
// range_low + (sum mod (range_high - range_low)), or range_low when that span
// is zero. A seed word (kind 1) loads both state words from splitmix64 and
// returns nothing. Words are taken one at a time: a draw occupies the block until
// the bit-serial divider, which makes one quotient bit per cycle, has finished
// (the divider is skipped when the span is zero); a seed occupies it for four
// passes through the shared bit-serial multiplier at one bit per cycle. After
// reset the block seeds itself with zero, holding in_stall high until that seed
// is done. A finished result waits in the output register while the next word
// is taken; a draw that completes while it still waits holds until the output
// is free.
module xorshift128plus_ranged_rng_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  kind,
  input  logic [63:0]           seed_value,
  input  logic signed [31:0]    range_low,
  input  logic [31:0]           range_high,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [63:0]           random_word,
  output logic signed [31:0]    ranged_value
);
  import xrng_pkg::*;

  typedef enum logic [2:0] {
    ST_BOOT,
    ST_IDLE,
    ST_MIX,
    ST_MULA,
    ST_MULB,
    ST_MOD,
    ST_WAIT
  } state_t;

  state_t    state;
  word_t     word_first;
  word_t     word_second;
  word_t     counter;
  logic      second_pass;
  word_t     sum_hold;
  range_t    low_hold;
  logic      span_zero;
  logic      out_load;

  unit_ctl_t mul_ctl;
  unit_sts_t mul_sts;
  word_t     mul_a;
  word_t     mul_b;
  word_t     mul_p;
  unit_ctl_t mod_ctl;
  unit_sts_t mod_sts;
  range_t    mod_divisor;
  range_t    mod_rem;

  // xorshift128+ step, evaluated on the current state words
  word_t  xs_a;
  word_t  xs_new;
  word_t  xs_sum;
  range_t span;
  word_t  mix_out;

  assign xs_a    = word_first ^ (word_first << XsShiftA);
  assign xs_new  = xs_a ^ word_second ^ (xs_a >> XsShiftB) ^ (word_second >> XsShiftC);
  assign xs_sum  = xs_new + word_second;
  assign span    = range_high - $unsigned(range_low);
  assign mix_out = (mul_p ^ (mul_p >> MixShift2)) | word_t'(1);

  assign in_stall = (state != ST_IDLE);

  // Load the output register when a result waits and the register is free
  assign out_load = (state == ST_WAIT) && (!out_valid || !out_stall);

  // Sequencer: state, state words and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_BOOT;
      out_valid     <= 1'b0;
      mul_ctl.start <= 1'b0;
      mod_ctl.start <= 1'b0;
      second_pass   <= 1'b0;
    end else begin
      mul_ctl.start <= 1'b0;
      mod_ctl.start <= 1'b0;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_BOOT: begin
          counter     <= GoldenStep;
          second_pass <= 1'b0;
          state       <= ST_MIX;
        end
        ST_IDLE: begin
          if (in_valid) begin
            if (kind) begin
              counter     <= seed_value + GoldenStep;
              second_pass <= 1'b0;
              state       <= ST_MIX;
            end else begin
              word_first    <= word_second;
              word_second   <= xs_new;
              sum_hold      <= xs_sum;
              low_hold      <= $unsigned(range_low);
              mod_divisor   <= span;
              span_zero     <= (span == '0);
              if (span == '0) begin
                state <= ST_WAIT;
              end else begin
                mod_ctl.start <= 1'b1;
                state         <= ST_MOD;
              end
            end
          end
        end
        ST_MIX: begin
          mul_a         <= counter ^ (counter >> MixShift0);
          mul_b         <= MixMulA;
          mul_ctl.start <= 1'b1;
          state         <= ST_MULA;
        end
        ST_MULA: begin
          if (mul_sts.done) begin
            mul_a         <= mul_p ^ (mul_p >> MixShift1);
            mul_b         <= MixMulB;
            mul_ctl.start <= 1'b1;
            state         <= ST_MULB;
          end
        end
        ST_MULB: begin
          if (mul_sts.done) begin
            if (!second_pass) begin
              word_first  <= mix_out;
              counter     <= counter + GoldenStep;
              second_pass <= 1'b1;
              state       <= ST_MIX;
            end else begin
              word_second <= mix_out;
              state       <= ST_IDLE;
            end
          end
        end
        ST_MOD: begin
          if (mod_sts.done) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          // Hold until the output register is free
          if (out_load) begin
            random_word  <= sum_hold;
            ranged_value <= $signed(low_hold + (span_zero ? '0 : mod_rem));
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  xrng_mul u_mul (
    .clk          (clk),
    .rst          (rst),
    .ctl          (mul_ctl),
    .multiplicand (mul_a),
    .multiplier   (mul_b),
    .sts          (mul_sts),
    .product      (mul_p)
  );

  xrng_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mod_ctl),
    .dividend  (sum_hold),
    .divisor   (mod_divisor),
    .sts       (mod_sts),
    .remainder (mod_rem)
  );

endmodule

// ===== tb/sv/xorshift128plus_ranged_rng_unit_tb.sv =====
// Testbench for xorshift128plus_ranged_rng_unit: random seed and draw words with a
// self-contained xorshift128+/splitmix64 predictor and an in-order result scoreboard.
// Depends on xrng_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module xorshift128plus_ranged_rng_unit_tb;
  import xrng_pkg::*;

  localparam logic KindDraw = 1'b0;
  localparam logic KindSeed = 1'b1;

  localparam int MaxIdle    = 19;
  localparam int RandWords  = 1800;
  localparam int LongHold   = 600;
  localparam int HoldAtWord = 150;
  localparam int DrainWait  = 300;
  localparam int MaxReports = 10;

  // Predicts each draw from its own copy of the two state words and queues the results
  class draw_scoreboard;
    word_t  lane_a;
    word_t  lane_b;
    word_t  pending_sum[$];
    range_t pending_ranged[$];
    int     mismatches;

    function new();
      mismatches = 0;
      seed_lanes('0);
    endfunction

    function word_t scramble(word_t count);
      word_t z;
      z = count;
      z = (z ^ (z >> MixShift0)) * MixMulA;
      z = (z ^ (z >> MixShift1)) * MixMulB;
      return z ^ (z >> MixShift2);
    endfunction

    // Load both lanes from two splitmix64 outputs, each forced odd
    function void seed_lanes(word_t seed);
      word_t count;
      count  = seed + GoldenStep;
      lane_a = scramble(count) | word_t'(1);
      count  = count + GoldenStep;
      lane_b = scramble(count) | word_t'(1);
    endfunction

    // One xorshift128+ step; returns the sum of the new lanes
    function word_t next_sum();
      word_t a;
      word_t b;
      a = lane_a;
      b = lane_b;
      a = a ^ (a << XsShiftA);
      a = a ^ b ^ (a >> XsShiftB) ^ (b >> XsShiftC);
      lane_a = b;
      lane_b = a;
      return a + b;
    endfunction

    function void note_word(logic k, word_t seed, range_t lo, range_t hi);
      word_t  sum;
      range_t span;
      word_t  offset;
      if (k == KindSeed) begin
        seed_lanes(seed);
      end else begin
        sum    = next_sum();
        span   = hi - lo;
        offset = (span != '0) ? (sum % {32'h0, span}) : '0;
        pending_sum.push_back(sum);
        pending_ranged.push_back(lo + offset[RangeW-1:0]);
      end
    endfunction

    function void check_draw(word_t sum, range_t ranged);
      word_t  want_sum;
      range_t want_ranged;
      if (pending_sum.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: unexpected result word %h / %h", $realtime, sum, ranged);
        return;
      end
      want_sum    = pending_sum.pop_front();
      want_ranged = pending_ranged.pop_front();
      if (sum !== want_sum || ranged !== want_ranged) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: random_word exp %h got %h, ranged_value exp %h got %h",
                   $realtime, want_sum, sum, want_ranged, ranged);
      end
    endfunction

    function int pending();
      return pending_sum.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                kind;
  logic [63:0]         seed_value;
  logic signed [31:0]  range_low;
  logic [31:0]         range_high;
  logic                out_valid;
  logic                out_stall;
  logic [63:0]         random_word;
  logic signed [31:0]  ranged_value;

  draw_scoreboard draws = new();
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;

  xorshift128plus_ranged_rng_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .seed_value   (seed_value),
    .range_low    (range_low),
    .range_high   (range_high),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .random_word  (random_word),
    .ranged_value (ranged_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watch both handshakes; values are the ones held before the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        draws.note_word(kind, seed_value, range_t'(range_low), range_high);
      if (out_valid && !out_stall)
        draws.check_draw(random_word, range_t'(ranged_value));
    end
  end

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(logic k, word_t seed, range_t lo, range_t hi);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, MaxIdle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    seed_value <= seed;
    range_low  <= lo;
    range_high <= hi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and hold off until every pending draw has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (draws.pending() > 0) @(posedge clk);
  endtask

  function automatic void pick_range(output range_t lo, output range_t hi);
    lo = $urandom;
    case ($urandom_range(0, 5))
      0, 1: hi = $urandom;
      2: hi = lo + $urandom_range(0, 16);
      3: hi = lo;
      4: hi = lo + (range_t'(1) << $urandom_range(0, RangeW - 1));
      default: hi = lo - $urandom_range(1, 1000);
    endcase
  endfunction

  // Receiver: random stalls per word, quiet stretches, one long hold-off
  initial begin : receiver
    int stall_cycles;
    int taken;
    taken = 0;
    out_stall <= 1'b0;
    forever begin
      if (taken % 50 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      if (taken == HoldAtWord) stall_cycles = LongHold;
      else stall_cycles = rx_quiet ? 0 : $urandom_range(0, MaxIdle);
      if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin : stimulus
    range_t lo;
    range_t hi;
    logic   k;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    kind       <= KindDraw;
    seed_value <= '0;
    range_low  <= '0;
    range_high <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: bound extremes, zero and inverted spans, ignored fields, seeds
    send_word(KindDraw, '0, 32'h0000_0000, 32'h0000_0000);
    send_word(KindDraw, '1, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(KindDraw, '0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(KindDraw, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(KindDraw, '0, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(KindDraw, '0, 32'd100, 32'd5);
    send_word(KindDraw, '0, 32'h0000_0000, 32'h8000_0000);
    send_word(KindDraw, '0, 32'hFFFF_FFFE, 32'h0000_0001);
    send_word(KindSeed, '0, 32'hFFFF_FFFF, 32'h1234_5678);
    send_word(KindDraw, '0, 32'h0000_0000, 32'd7);
    send_word(KindSeed, '1, 32'h0000_0000, 32'h0000_0000);
    send_word(KindDraw, '0, 32'h8000_0000, 32'h8000_0000);
    send_word(KindSeed, 64'h8000_0000_0000_0000, 32'h0, 32'h0);
    send_word(KindSeed, 64'h0123_4567_89AB_CDEF, 32'h0, 32'h0);
    send_word(KindDraw, '1, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(KindDraw, 64'h5555_AAAA_5555_AAAA, 32'd1, 32'd3);
    send_word(KindDraw, '0, 32'd1, 32'd2);
    drain();

    // Random: mostly draws over mixed spans, reseeding now and then
    for (int i = 0; i < RandWords; i++) begin
      if (i % 64 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
      if (i == RandWords / 2) drain();
      k = ($urandom_range(0, 7) == 0) ? KindSeed : KindDraw;
      pick_range(lo, hi);
      send_word(k, {$urandom, $urandom}, lo, hi);
    end
    drain();
    repeat (DrainWait) @(posedge clk);

    if (draws.mismatches == 0 && draws.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #12_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
